// ----- rtl/core/base64_encode_decode_unit_macros.svh -----
// assertion helpers for the base64 codec
`ifndef BASE64_ENCODE_DECODE_UNIT_MACROS_SVH
`define BASE64_ENCODE_DECODE_UNIT_MACROS_SVH

// condition holds at every edge outside reset
`define B64_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define B64_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/b64_pkg.sv -----
`default_nettype none
package b64_pkg;

	// default depth of the job queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [6:0] INVALID_VALUE = 7'd64;

	// codec direction codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// one finished group: up to four results, first result in res[0]
	typedef struct packed {
		logic [3:0][7:0] res;
		logic [2:0]      count;
		logic            last;
		logic            err;
	} b64_job_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] ve;
		ve = {2'b00, v};
		if (v < 6'd26) begin
			enc_char = ve + 8'h41;
		end else if (v < 6'd52) begin
			enc_char = ve + 8'h47;
		end else if (v < 6'd62) begin
			enc_char = ve - 8'h04;
		end else if (v == 6'd62) begin
			enc_char = 8'h2B;
		end else begin
			enc_char = 8'h2F;
		end
	endfunction

	// character to 6-bit value, pad reads as zero, anything else invalid
	function automatic logic [6:0] dec_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		case (c) inside
			[8'h41:8'h5A]: begin
				d = c - 8'h41;
			end
			[8'h61:8'h7A]: begin
				d = c - 8'h47;
			end
			[8'h30:8'h39]: begin
				d = c + 8'h04;
			end
			8'h2B: begin
				d = 8'd62;
			end
			8'h2F: begin
				d = 8'd63;
			end
			PAD_CHAR: begin
				d = 8'd0;
			end
			default: begin
				d = {1'b0, INVALID_VALUE};
			end
		endcase
		dec_value = d[6:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/b64_front.sv -----
`default_nettype none
module b64_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic              cfg_dir,
	input  wire logic              item_take,
	input  wire logic [7:0]        item_byte,
	input  wire logic              item_last,
	output logic                   push,
	output b64_pkg::b64_job_t      job
);
	import b64_pkg::*;

	logic        dir_q;
	logic [23:0] buf_q;
	logic [1:0]  cnt_q;
	logic        err_q;
	logic        prev_pad_q;
	logic        seen_q;

	logic [1:0]  enc_k;
	logic [2:0]  held;
	logic [23:0] enc_buf;
	logic        enc_emit;
	logic [6:0]  v;
	logic        is_pad;
	logic        complete;
	logic [23:0] dec_buf;
	logic        dec_err;
	logic        dec_emit;
	logic [1:0]  drop;
	logic        emit;

	// encode: merge the byte into the group
	always_comb begin
		enc_k = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
		held  = {1'b0, enc_k} + 3'd1;
		case (enc_k)
			2'd1: begin
				enc_buf = buf_q | {8'h00, item_byte, 8'h00};
			end
			2'd2: begin
				enc_buf = buf_q | {16'h0000, item_byte};
			end
			default: begin
				enc_buf = buf_q | {item_byte, 16'h0000};
			end
		endcase
		enc_emit = (held == 3'd3) || item_last;
	end

	// decode: classify the character and merge its six bits
	always_comb begin
		v        = dec_value(item_byte);
		is_pad   = (item_byte == PAD_CHAR);
		complete = (cnt_q == 2'd3);
		dec_err  = err_q | (v == INVALID_VALUE);
		case (cnt_q)
			2'd0: begin
				dec_buf = {v[5:0], 2'b00, 16'h0000};
			end
			2'd1: begin
				dec_buf = buf_q | {5'b0, v[6:4], 16'h0000} | {8'h00, v[3:0], 4'b0, 8'h00};
			end
			2'd2: begin
				dec_buf = buf_q | {11'b0, v[6:2], 8'h00} | {16'h0000, v[1:0], 6'b0};
			end
			default: begin
				dec_buf = buf_q | {17'b0, v};
			end
		endcase
		dec_emit = complete || item_last;
		drop = 2'd0;
		if (item_last && (seen_q || complete)) begin
			drop = {1'b0, is_pad} + {1'b0, prev_pad_q};
		end
	end

	// build the job for the back end
	always_comb begin
		job = '0;
		if (dir_q == DIR_DECODE) begin
			emit       = dec_emit;
			job.res[0] = dec_buf[23:16];
			job.res[1] = dec_buf[15:8];
			job.res[2] = dec_buf[7:0];
			job.res[3] = 8'h00;
			job.count  = 3'd3 - {1'b0, drop};
			job.err    = dec_err || !complete;
		end else begin
			emit       = enc_emit;
			job.res[0] = enc_char(enc_buf[23:18]);
			job.res[1] = enc_char({enc_buf[17:16], enc_buf[15:12]});
			job.res[2] = (held < 3'd2) ? PAD_CHAR : enc_char({enc_buf[11:8], enc_buf[7:6]});
			job.res[3] = (held < 3'd3) ? PAD_CHAR : enc_char(enc_buf[5:0]);
			job.count  = 3'd4;
			job.err    = 1'b0;
		end
		job.last = item_last;
		push     = item_take && emit;
	end

	// group and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= DIR_ENCODE;
			buf_q      <= '0;
			cnt_q      <= '0;
			err_q      <= 1'b0;
			prev_pad_q <= 1'b0;
			seen_q     <= 1'b0;
		end else if (cfg_write) begin
			dir_q      <= cfg_dir;
			buf_q      <= '0;
			cnt_q      <= '0;
			err_q      <= 1'b0;
			prev_pad_q <= 1'b0;
			seen_q     <= 1'b0;
		end else if (item_take) begin
			if (emit && item_last) begin
				buf_q      <= '0;
				cnt_q      <= '0;
				err_q      <= 1'b0;
				prev_pad_q <= 1'b0;
				seen_q     <= 1'b0;
			end else if (dir_q == DIR_DECODE) begin
				prev_pad_q <= is_pad;
				if (emit) begin
					buf_q  <= '0;
					cnt_q  <= '0;
					err_q  <= 1'b0;
					seen_q <= 1'b1;
				end else begin
					buf_q <= dec_buf;
					cnt_q <= cnt_q + 2'd1;
					err_q <= dec_err;
				end
			end else begin
				if (emit) begin
					buf_q <= '0;
					cnt_q <= '0;
				end else begin
					buf_q <= enc_buf;
					cnt_q <= held[1:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/b64_queue.sv -----
`default_nettype none
module b64_queue #(
	parameter int unsigned Depth = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire b64_pkg::b64_job_t push_job,
	input  wire logic              pop,
	output b64_pkg::b64_job_t      head,
	output logic                   full,
	output logic                   nempty
);
	import b64_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	b64_job_t          slots_q [Depth];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   rd_q;
	logic [CntW-1:0]   fill_q;

	assign full   = (fill_q == CntW'(Depth));
	assign nempty = (fill_q != '0);
	assign head   = slots_q[rd_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CntW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/b64_back.sv -----
`default_nettype none
module b64_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_nempty,
	input  wire b64_pkg::b64_job_t q_head,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   out_final,
	output logic                   out_err
);
	import b64_pkg::*;

	b64_job_t   job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_final_q;
	logic       out_err_q;

	logic advance;
	logic job_done;

	assign advance  = !out_valid_q || out_ready;
	assign job_done = ({1'b0, idx_q} == (job_q.count - 3'd1));
	assign q_pop    = q_nempty && (!job_valid_q || (advance && job_done));

	// job walk, one result per cycle while the output register is empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (advance && job_valid_q) begin
				if (job_done) begin
					job_valid_q <= 1'b0;
				end
				idx_q <= idx_q + 2'd1;
			end
			if (advance) begin
				out_valid_q <= job_valid_q;
			end
		end
	end

	// job payload and output register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (advance) begin
			out_byte_q  <= job_q.res[idx_q];
			out_final_q <= job_q.last && job_done;
			out_err_q   <= job_q.err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_final = out_final_q;
	assign out_err   = out_err_q;

endmodule
`default_nettype wire

// ----- rtl/core/base64_encode_decode_unit.sv -----
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata[7:0] data_byte, tlast end_of_message
// m_*       out  m_tvalid/m_tready    tdata[7:0] out_byte, tlast final_result, tuser error_flag
// cfg_*     in   cfg_valid/cfg_ready  cfg_data codec_direction (0 encode, 1 decode)
//
// one input item is taken per cycle while the job queue has room; the back end
// sends one result per cycle while m_tready does not hold it; encoding, with four
// results for three items, is held back by the single result port, decoding is not.
// a closed group's job passes through a queue slot and the job register to the output.
// reset clears the group state and selects encoding; cfg_ready is always high.
// a low m_tready holds the output register, the queue then fills and s_tready drops.
`default_nettype none
`include "base64_encode_decode_unit_macros.svh"
module base64_encode_decode_unit #(
	parameter int unsigned QueueDepth = b64_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast,
	output logic            m_tuser,   // [0] error_flag
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data
);
	import b64_pkg::*;

	logic     item_take;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_nempty;
	logic     job_count_ok;
	b64_job_t push_job;
	b64_job_t q_head;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign item_take = s_tvalid && s_tready;

	// front: group assembly and classification
	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_dir   (cfg_data),
		.item_take (item_take),
		.item_byte (s_tdata),
		.item_last (s_tlast),
		.push      (q_push),
		.job       (push_job)
	);

	// job queue between front and back
	b64_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.nempty   (q_nempty)
	);

	// back: result sequencing and output register
	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nempty  (q_nempty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_final (m_tlast),
		.out_err   (m_tuser)
	);

	// checks
	assign job_count_ok = (q_head.count != 3'd0) && (q_head.count <= 3'd4);

	`B64_ASSERT_IMPLY(a_no_overflow, q_full, !q_push, "job pushed into a full queue")
	`B64_ASSERT_IMPLY(a_job_count, q_pop, job_count_ok, "job with bad result count")
	`B64_ASSERT_ALWAYS(a_pop_needs_data, !q_pop || q_nempty, "pop from an empty queue")

endmodule
`default_nettype wire
